@@ rtl/triangle_unit_normal_defines.svh @@
// ----------------------------------------------------------------------------
// Triangle unit normal assertion macros
// Shared concurrent check templates clocked on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// same-cycle implication
`define TUN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("triangle_unit_normal: check failed");

// next-cycle implication
`define TUN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("triangle_unit_normal: check failed");

`endif

@@ rtl/tun_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Widths, sideband type and payload types shared by the cells and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

  localparam int COORD_BITS       = 24;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int OUT_WIDTH        = 16;

  localparam int EW   = COORD_BITS + 1;
  localparam int PW   = 2 * EW;
  localparam int NCW  = PW + 1;
  localparam int MW   = NCW - 1;
  localparam int NSTG = $clog2(MW);
  localparam int NW   = 1 << NSTG;
  localparam int NT   = 30;
  localparam int SW   = 2 * NT + 2;
  localparam int LW   = NT + 1;
  localparam int SQ_CELLS = NT + 1;
  localparam int KSW  = $clog2(NT + 1);
  localparam int KDW  = $clog2(OUT_WIDTH);
  localparam int NUMW = NT + NORMAL_FRAC_BITS + 1;
  localparam int DW   = (NUMW > LW + OUT_WIDTH) ? NUMW : LW + OUT_WIDTH;

  typedef struct packed {
    logic       vld;
    logic       degen;
    logic [2:0] neg;
    logic [2:0] ovf;
  } tun_side_t;

  typedef logic [NW-1:0]        nmag_t;
  typedef logic [NT-1:0]        amag_t;
  typedef logic [SW-1:0]        sq_t;
  typedef logic [LW-1:0]        len_t;
  typedef logic [DW-1:0]        drem_t;
  typedef logic [OUT_WIDTH-1:0] quo_t;

endpackage

`default_nettype wire

@@ rtl/tun_norm_cell.sv @@
// ----------------------------------------------------------------------------
// Normalize cell
// Shifts all three magnitudes left by a fixed step when the top bits are clear.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_norm_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [tun_pkg::NSTG-1:0]       shamt,
  input  tun_pkg::tun_side_t             side_in,
  input  tun_pkg::nmag_t [2:0]           mag_in,
  output tun_pkg::tun_side_t             side_out,
  output tun_pkg::nmag_t [2:0]           mag_out
);
  import tun_pkg::*;

  nmag_t [2:0] mag_next;
  logic        top_clear;

  always_comb begin
    top_clear = 1'b1;
    for (int j = 0; j < 3; j++) begin
      if ((mag_in[j] >> (NW - int'(shamt))) != '0) top_clear = 1'b0;
    end
    for (int j = 0; j < 3; j++) begin
      mag_next[j] = top_clear ? (mag_in[j] << shamt) : mag_in[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_out <= mag_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tun_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// One root bit per cell; magnitudes ride along for the divide.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_sqrt_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [tun_pkg::KSW-1:0]   k,
  input  tun_pkg::tun_side_t        side_in,
  input  tun_pkg::amag_t [2:0]      a_in,
  input  tun_pkg::sq_t              rem_in,
  input  tun_pkg::sq_t              root_in,
  output tun_pkg::tun_side_t        side_out,
  output tun_pkg::amag_t [2:0]      a_out,
  output tun_pkg::sq_t              rem_out,
  output tun_pkg::sq_t              root_out
);
  import tun_pkg::*;

  sq_t bitv;
  sq_t trial;
  sq_t rem_next;
  sq_t root_next;

  always_comb begin
    bitv  = sq_t'(1) << (2 * k);
    trial = root_in + bitv;
    if (rem_in >= trial) begin
      rem_next  = rem_in - trial;
      root_next = (root_in >> 1) + bitv;
    end else begin
      rem_next  = rem_in;
      root_next = root_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_out    <= a_in;
      rem_out  <= rem_next;
      root_out <= root_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tun_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divide cell
// One restoring quotient bit per cell for the x, y and z lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_div_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [tun_pkg::KDW-1:0]   k,
  input  tun_pkg::tun_side_t        side_in,
  input  tun_pkg::len_t             len_in,
  input  tun_pkg::drem_t [2:0]      rem_in,
  input  tun_pkg::quo_t [2:0]       q_in,
  output tun_pkg::tun_side_t        side_out,
  output tun_pkg::len_t             len_out,
  output tun_pkg::drem_t [2:0]      rem_out,
  output tun_pkg::quo_t [2:0]       q_out
);
  import tun_pkg::*;

  drem_t        d;
  drem_t [2:0]  rem_next;
  quo_t  [2:0]  q_next;

  always_comb begin
    d = drem_t'(len_in) << k;
    for (int j = 0; j < 3; j++) begin
      if (rem_in[j] >= d) begin
        rem_next[j] = rem_in[j] - d;
        q_next[j]   = {q_in[j][OUT_WIDTH-2:0], 1'b1};
      end else begin
        rem_next[j] = rem_in[j];
        q_next[j]   = {q_in[j][OUT_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_out <= len_in;
      rem_out <= rem_next;
      q_out   <= q_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/triangle_unit_normal.sv @@
// ----------------------------------------------------------------------------
// Triangle unit normal
// Cross product of two triangle edges, scaled to unit length in Q1.14.
// ----------------------------------------------------------------------------
// Throughput: one triangle per cycle while the output is not held; the
// pipeline of normalize, square root (31 cells) and divide (16 cells)
// stages advances as one.
// A held output stalls the whole pipeline and drops in_ready.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none

module triangle_unit_normal (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [tun_pkg::COORD_BITS-1:0] v1_x,
  input  logic signed [tun_pkg::COORD_BITS-1:0] v1_y,
  input  logic signed [tun_pkg::COORD_BITS-1:0] v1_z,
  input  logic signed [tun_pkg::COORD_BITS-1:0] v2_x,
  input  logic signed [tun_pkg::COORD_BITS-1:0] v2_y,
  input  logic signed [tun_pkg::COORD_BITS-1:0] v2_z,
  input  logic signed [tun_pkg::COORD_BITS-1:0] v3_x,
  input  logic signed [tun_pkg::COORD_BITS-1:0] v3_y,
  input  logic signed [tun_pkg::COORD_BITS-1:0] v3_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tun_pkg::OUT_WIDTH-1:0]  normal_x,
  output logic signed [tun_pkg::OUT_WIDTH-1:0]  normal_y,
  output logic signed [tun_pkg::OUT_WIDTH-1:0]  normal_z,
  output logic                                  degenerate
);
  import tun_pkg::*;

  `include "triangle_unit_normal_defines.svh"

  localparam quo_t POS_LIM = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam quo_t NEG_LIM = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // edges
  logic                 s1_vld;
  logic signed [EW-1:0] e [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e[0] <= EW'(v2_x) - EW'(v1_x);
      e[1] <= EW'(v2_y) - EW'(v1_y);
      e[2] <= EW'(v2_z) - EW'(v1_z);
      e[3] <= EW'(v3_x) - EW'(v1_x);
      e[4] <= EW'(v3_y) - EW'(v1_y);
      e[5] <= EW'(v3_z) - EW'(v1_z);
    end
  end

  // products
  logic                 s2_vld;
  logic signed [PW-1:0] p [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= e[1] * e[5];
      p[1] <= e[2] * e[4];
      p[2] <= e[2] * e[3];
      p[3] <= e[0] * e[5];
      p[4] <= e[0] * e[4];
      p[5] <= e[1] * e[3];
    end
  end

  // cross product, sign and magnitude
  logic signed [NCW-1:0] n [3];
  logic signed [NCW-1:0] n_abs [3];
  nmag_t [2:0]           mag_c;
  tun_side_t             side_c;

  always_comb begin
    n[0] = NCW'(p[0]) - NCW'(p[1]);
    n[1] = NCW'(p[2]) - NCW'(p[3]);
    n[2] = NCW'(p[4]) - NCW'(p[5]);
    side_c = '0;
    side_c.vld = s2_vld;
    for (int j = 0; j < 3; j++) begin
      side_c.neg[j] = n[j][NCW-1];
      n_abs[j]      = n[j][NCW-1] ? -n[j] : n[j];
      mag_c[j]      = NW'(n_abs[j][MW-1:0]);
    end
    side_c.degen = (mag_c[0] == '0) && (mag_c[1] == '0) && (mag_c[2] == '0);
  end

  tun_side_t   nside [NSTG+1];
  nmag_t [2:0] nmag  [NSTG+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      nside[0] <= '0;
    end else if (en) begin
      nside[0] <= side_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nmag[0] <= mag_c;
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_norm
    tun_norm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .shamt    (NSTG'(1 << (NSTG - 1 - i))),
      .side_in  (nside[i]),
      .mag_in   (nmag[i]),
      .side_out (nside[i+1]),
      .mag_out  (nmag[i+1])
    );
  end

  // squares and sum
  amag_t [2:0]       a_n;
  tun_side_t         sq_side;
  amag_t [2:0]       sq_a;
  logic [2*NT-1:0]   sq [3];
  tun_side_t         sum_side;
  amag_t [2:0]       sum_a;
  sq_t               sum;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      a_n[j] = nmag[NSTG][j][NW-1 -: NT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_side  <= '0;
      sum_side <= '0;
    end else if (en) begin
      sq_side  <= nside[NSTG];
      sum_side <= sq_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_a  <= a_n;
      sq[0] <= a_n[0] * a_n[0];
      sq[1] <= a_n[1] * a_n[1];
      sq[2] <= a_n[2] * a_n[2];
      sum_a <= sq_a;
      sum   <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
    end
  end

  // square root chain
  tun_side_t   sside [SQ_CELLS+1];
  amag_t [2:0] sa    [SQ_CELLS+1];
  sq_t         srem  [SQ_CELLS+1];
  sq_t         sroot [SQ_CELLS+1];

  assign sside[0] = sum_side;
  assign sa[0]    = sum_a;
  assign srem[0]  = sum;
  assign sroot[0] = '0;

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .k        (KSW'(NT - i)),
      .side_in  (sside[i]),
      .a_in     (sa[i]),
      .rem_in   (srem[i]),
      .root_in  (sroot[i]),
      .side_out (sside[i+1]),
      .a_out    (sa[i+1]),
      .rem_out  (srem[i+1]),
      .root_out (sroot[i+1])
    );
  end

  // divide setup: rounding offset and overflow
  len_t             len_c;
  logic [NUMW-1:0]  num_c [3];
  tun_side_t        pside_c;
  drem_t [2:0]      prem_c;

  always_comb begin
    len_c   = sroot[SQ_CELLS][LW-1:0];
    pside_c = sside[SQ_CELLS];
    for (int j = 0; j < 3; j++) begin
      num_c[j] = (NUMW'(sa[SQ_CELLS][j]) << NORMAL_FRAC_BITS) + NUMW'(len_c >> 1);
      prem_c[j] = DW'(num_c[j]);
      pside_c.ovf[j] = prem_c[j] >= (DW'(len_c) << OUT_WIDTH);
    end
  end

  tun_side_t   dside [OUT_WIDTH+1];
  len_t        dlen  [OUT_WIDTH+1];
  drem_t [2:0] drem  [OUT_WIDTH+1];
  quo_t  [2:0] dq    [OUT_WIDTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dside[0] <= '0;
    end else if (en) begin
      dside[0] <= pside_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dlen[0] <= len_c;
      drem[0] <= prem_c;
    end
  end

  assign dq[0] = '0;

  for (genvar i = 0; i < OUT_WIDTH; i++) begin : g_div
    tun_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .k        (KDW'(OUT_WIDTH - 1 - i)),
      .side_in  (dside[i]),
      .len_in   (dlen[i]),
      .rem_in   (drem[i]),
      .q_in     (dq[i]),
      .side_out (dside[i+1]),
      .len_out  (dlen[i+1]),
      .rem_out  (drem[i+1]),
      .q_out    (dq[i+1])
    );
  end

  // saturate, sign, output register
  tun_side_t  fside;
  quo_t [2:0] qs;
  quo_t [2:0] res;

  always_comb begin
    fside = dside[OUT_WIDTH];
    for (int j = 0; j < 3; j++) begin
      if (fside.neg[j]) begin
        qs[j]  = (fside.ovf[j] || dq[OUT_WIDTH][j] > NEG_LIM) ? NEG_LIM : dq[OUT_WIDTH][j];
        res[j] = '0 - qs[j];
      end else begin
        qs[j]  = (fside.ovf[j] || dq[OUT_WIDTH][j] > POS_LIM) ? POS_LIM : dq[OUT_WIDTH][j];
        res[j] = qs[j];
      end
      if (fside.degen) res[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fside.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal_x   <= res[0];
      normal_y   <= res[1];
      normal_z   <= res[2];
      degenerate <= fside.degen;
    end
  end

  `TUN_ASSERT_IMPL(a_degen_zero, out_valid && degenerate,
    normal_x == '0 && normal_y == '0 && normal_z == '0)
  `TUN_ASSERT_IMPL(a_nondegen_nonzero, out_valid && !degenerate,
    normal_x != '0 || normal_y != '0 || normal_z != '0)
  `TUN_ASSERT_IMPL(a_unit_range, out_valid && !degenerate,
    normal_x >= -16'sd16384 && normal_x <= 16'sd16384 &&
    normal_y >= -16'sd16384 && normal_y <= 16'sd16384)
  `TUN_ASSERT_NEXT(a_last_stage_lands, en && fside.vld, out_valid)

endmodule

`default_nettype wire
